// ===== sv/pfm_pkg.sv =====
// shared widths, command and status types of the page fault mapper
package pfm_pkg;

  localparam int ADDR_W   = 32;
  localparam int FRAME_W  = 20;
  localparam int IDX_W    = 10;
  localparam int DIR_LSB  = 22;
  localparam int PAGE_LSB = 12;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic load_base;
    logic dir_clr_step;
    logic dir_create;
    logic page_clr_step;
    logic set_identity;
    logic page_take;
    logic page_write;
    logic load_result;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic dir_clear_last;
    logic dir_is_zero;
    logic dir_valid;
    logic page_clear_last;
    logic page_valid;
    logic out_free;
  } status_t;

endpackage

// ===== sv/pfm_fault_if.sv =====
// fault request channel and mapping result channel
interface pfm_fault_if;
  logic                         valid;
  logic                         ready;
  logic [pfm_pkg::ADDR_W-1:0]   logical_address;
  logic [pfm_pkg::FRAME_W-1:0]  kernel_frame;
  logic [pfm_pkg::FRAME_W-1:0]  process_frame;

  modport source (output valid, output logical_address, output kernel_frame,
                  output process_frame, input ready);
  modport sink (input valid, input logical_address, input kernel_frame,
                input process_frame, output ready);
endinterface

interface pfm_map_if;
  logic                         valid;
  logic                         ready;
  logic [pfm_pkg::FRAME_W-1:0]  mapped_frame;
  logic                         table_created;
  logic                         page_created;

  modport source (output valid, output mapped_frame, output table_created,
                  output page_created, input ready);
  modport sink (input valid, input mapped_frame, input table_created,
                input page_created, output ready);
endinterface

// ===== sv/two_level_page_fault_mapper.sv =====
// top level of the two-level page fault mapper
//
// fault channel (sink): one beat per faulting address, with a spare kernel
// frame for a new page table and a spare process frame for the page.
// mapping channel (source): one beat per fault with the mapped frame and
// flags telling which spare frames were consumed.
// cfg_we / cfg_wdata load the frame of the identity-mapped first table.
// after reset the directory memory is swept, one entry a cycle while no
// config write takes the port; no fault is taken meanwhile, config writes
// are. a fault beat is registered, its directory entry read and checked:
// table 0 is identity-mapped, an existing entry leads to a page entry read,
// and a new page table is built by clearing its valid bits one entry a
// cycle through the single page memory port before the page is written.
// one fault is worked at a time; the next is taken the cycle after the
// result goes into the output register, so a stalled receiver holds the
// block only once a second result is ready to be registered.
module two_level_page_fault_mapper #(
  parameter int TABLE_ENTRIES     = 1024,
  parameter int DIRECTORY_ENTRIES = 1024,
  parameter int FRAME_BITS        = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pfm_pkg::FRAME_W-1:0] cfg_wdata,
  pfm_fault_if.sink                   fault,
  pfm_map_if.source                   mapping
);

  pfm_pkg::cmd_t    cmd;
  pfm_pkg::status_t status;
  logic             in_ready;

  // handshake of the fault channel lives in the controller
  assign fault.ready = in_ready;

  pfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fault.valid),
    .in_ready (in_ready),
    .cfg_we   (cfg_we),
    .status   (status),
    .cmd      (cmd)
  );

  // indexes, memories and the output register
  pfm_datapath #(
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .DIRECTORY_ENTRIES (DIRECTORY_ENTRIES),
    .FRAME_BITS        (FRAME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .logical_address (fault.logical_address),
    .kernel_frame    (fault.kernel_frame),
    .process_frame   (fault.process_frame),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (mapping.ready),
    .out_valid       (mapping.valid),
    .mapped_frame    (mapping.mapped_frame),
    .table_created   (mapping.table_created),
    .page_created    (mapping.page_created)
  );

endmodule

// ===== sv/pfm_ram.sv =====
// generic single-port ram with registered read
module pfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/pfm_datapath.sv =====
// index registers, directory and page memories, result register
module pfm_datapath #(
  parameter int TABLE_ENTRIES     = 1024,
  parameter int DIRECTORY_ENTRIES = 1024,
  parameter int FRAME_BITS        = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pfm_pkg::cmd_t               cmd,
  output pfm_pkg::status_t            status,
  input  logic [pfm_pkg::ADDR_W-1:0]  logical_address,
  input  logic [pfm_pkg::FRAME_W-1:0] kernel_frame,
  input  logic [pfm_pkg::FRAME_W-1:0] process_frame,
  input  logic                        cfg_we,
  input  logic [pfm_pkg::FRAME_W-1:0] cfg_wdata,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pfm_pkg::FRAME_W-1:0] mapped_frame,
  output logic                        table_created,
  output logic                        page_created
);

  localparam int DIR_AW  = $clog2(DIRECTORY_ENTRIES);
  localparam int PG_AW   = $clog2(TABLE_ENTRIES);
  localparam int PAGE_AW = $clog2(DIRECTORY_ENTRIES * TABLE_ENTRIES);
  localparam int ENT_W   = FRAME_BITS + 1;
  localparam logic [16:0] DIR_MOD = 17'(DIRECTORY_ENTRIES);
  localparam logic [16:0] PG_MOD  = 17'(TABLE_ENTRIES);
  localparam logic [PAGE_AW-1:0] TBL_STRIDE = PAGE_AW'(TABLE_ENTRIES);

  // index wrap by conditional subtraction, moduli of at least 8
  function automatic logic [9:0] wrap_index(input logic [9:0] v, input logic [16:0] m);
    logic [16:0] r;
    r = {7'd0, v};
    for (int k = 6; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return r[9:0];
  endfunction

  logic [FRAME_BITS-1:0] first_frame;
  logic [DIR_AW-1:0]     dclr_cnt;
  logic [PG_AW-1:0]      pcnt;
  logic [DIR_AW-1:0]     dir_idx;
  logic [PG_AW-1:0]      pg_idx;
  logic [PAGE_AW-1:0]    base;
  logic [FRAME_BITS-1:0] kframe;
  logic [FRAME_BITS-1:0] pframe;
  logic [FRAME_BITS-1:0] mapped;
  logic                  table_made;
  logic                  page_made;

  logic [9:0]            dir_wrapped;
  logic [9:0]            pg_wrapped;
  logic [pfm_pkg::FRAME_W-1:0] pg_ext;

  logic                  dir_we;
  logic [DIR_AW-1:0]     dir_addr;
  logic [ENT_W-1:0]      dir_wdata;
  logic [ENT_W-1:0]      dir_rdata;

  logic                  page_we;
  logic [PG_AW-1:0]      page_off;
  logic [PAGE_AW-1:0]    page_addr;
  logic [ENT_W-1:0]      page_wdata;
  logic [ENT_W-1:0]      page_rdata;

  assign dir_wrapped = wrap_index(logical_address[pfm_pkg::DIR_LSB +: pfm_pkg::IDX_W], DIR_MOD);
  assign pg_wrapped  = wrap_index(logical_address[pfm_pkg::PAGE_LSB +: pfm_pkg::IDX_W], PG_MOD);
  assign pg_ext      = pfm_pkg::FRAME_W'(pg_idx);

  // directory port: config write, clearing pass, table creation, else read
  always_comb begin
    dir_addr  = dir_idx;
    dir_we    = 1'b0;
    dir_wdata = {1'b1, kframe};
    if (cfg_we) begin
      dir_addr  = '0;
      dir_we    = 1'b1;
      dir_wdata = {1'b1, cfg_wdata[FRAME_BITS-1:0]};
    end else if (cmd.dir_clr_step) begin
      dir_addr  = dclr_cnt;
      dir_we    = 1'b1;
      dir_wdata = (dclr_cnt == '0) ? {1'b1, first_frame} : '0;
    end else if (cmd.dir_create) begin
      dir_we    = 1'b1;
    end
  end

  assign page_off   = cmd.page_clr_step ? pcnt : pg_idx;
  assign page_addr  = base + PAGE_AW'(page_off);
  assign page_we    = cmd.page_clr_step | cmd.page_write;
  assign page_wdata = cmd.page_clr_step ? '0 : {1'b1, pframe};

  pfm_ram #(.WIDTH(ENT_W), .DEPTH(DIRECTORY_ENTRIES)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  pfm_ram #(.WIDTH(ENT_W), .DEPTH(DIRECTORY_ENTRIES * TABLE_ENTRIES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .addr  (page_addr),
    .wdata (page_wdata),
    .rdata (page_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= FRAME_BITS'(1);
      dclr_cnt    <= '0;
      pcnt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_frame <= cfg_wdata[FRAME_BITS-1:0];
      end
      if (cmd.dir_clr_step && !cfg_we) begin
        dclr_cnt <= dclr_cnt + 1'b1;
      end
      if (cmd.dir_create) begin
        pcnt <= '0;
      end else if (cmd.page_clr_step) begin
        pcnt <= pcnt + 1'b1;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      dir_idx    <= dir_wrapped[DIR_AW-1:0];
      pg_idx     <= pg_wrapped[PG_AW-1:0];
      kframe     <= kernel_frame[FRAME_BITS-1:0];
      pframe     <= process_frame[FRAME_BITS-1:0];
      table_made <= 1'b0;
      page_made  <= 1'b0;
    end
    if (cmd.load_base) begin
      base <= PAGE_AW'(dir_idx) * TBL_STRIDE;
    end
    if (cmd.dir_create) begin
      table_made <= 1'b1;
    end
    if (cmd.set_identity) begin
      mapped <= pg_ext[FRAME_BITS-1:0];
    end else if (cmd.page_take) begin
      mapped <= page_rdata[FRAME_BITS-1:0];
    end else if (cmd.page_write) begin
      mapped    <= pframe;
      page_made <= 1'b1;
    end
    if (cmd.load_result) begin
      mapped_frame  <= pfm_pkg::FRAME_W'(mapped);
      table_created <= table_made;
      page_created  <= page_made;
    end
  end

  always_comb begin
    status.dir_clear_last  = (dclr_cnt == DIR_AW'(DIRECTORY_ENTRIES - 1));
    status.dir_is_zero     = (dir_idx == '0);
    status.dir_valid       = dir_rdata[FRAME_BITS];
    status.page_clear_last = (pcnt == PG_AW'(TABLE_ENTRIES - 1));
    status.page_valid      = page_rdata[FRAME_BITS];
    status.out_free        = !out_valid || out_ready;
  end

endmodule

// ===== sv/pfm_ctrl.sv =====
// sequencing state machine of the page fault mapper
module pfm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cfg_we,
  input  pfm_pkg::status_t status,
  output pfm_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DREAD  = 8'b0000_0100,
    S_DCHECK = 8'b0000_1000,
    S_PCLEAR = 8'b0001_0000,
    S_PCHECK = 8'b0010_0000,
    S_PWRITE = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        // config write takes the directory port, the sweep waits
        cmd.dir_clr_step = !cfg_we;
        if (!cfg_we && status.dir_clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_next = S_DREAD;
        end
      end
      S_DREAD: begin
        cmd.load_base = 1'b1;
        state_next    = S_DCHECK;
      end
      S_DCHECK: begin
        if (status.dir_is_zero) begin
          cmd.set_identity = 1'b1;
          state_next       = S_RESULT;
        end else if (!status.dir_valid) begin
          cmd.dir_create = 1'b1;
          state_next     = S_PCLEAR;
        end else begin
          state_next = S_PCHECK;
        end
      end
      S_PCLEAR: begin
        cmd.page_clr_step = 1'b1;
        if (status.page_clear_last) begin
          state_next = S_PWRITE;
        end
      end
      S_PCHECK: begin
        if (status.page_valid) begin
          cmd.page_take = 1'b1;
        end else begin
          cmd.page_write = 1'b1;
        end
        state_next = S_RESULT;
      end
      S_PWRITE: begin
        cmd.page_write = 1'b1;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/pfm_checker.sv =====
// port-level checks of the page fault mapper and their bind
module pfm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pfm_pkg::FRAME_W-1:0] mapped_frame,
  input logic                        table_created,
  input logic                        page_created
);

  // a held result beat keeps its mapped frame
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mapped_frame))
    else $error("result beat changed while stalled");

  // one fault at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second fault taken while one in flight");

  // a new result never appears while the block is free to take faults
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result beat without a fault in progress");

  // directory sweep after reset holds off faults
  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("fault taken before the directory sweep");

  // a new table always gets its faulting page
  a_table_implies_page: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !table_created || page_created)
    else $error("table built without mapping the page");

endmodule

bind two_level_page_fault_mapper pfm_checker u_pfm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (fault.valid),
  .in_ready      (fault.ready),
  .out_valid     (mapping.valid),
  .out_ready     (mapping.ready),
  .mapped_frame  (mapping.mapped_frame),
  .table_created (mapping.table_created),
  .page_created  (mapping.page_created)
);

// ===== tb/two_level_page_fault_mapper_test.sv =====
// self-checking regression for the two-level page fault mapper
`timescale 1ns / 1ps

module two_level_page_fault_mapper_test;

  // block sizes, kept at their full values
  localparam int TBL_ENTRIES = 1024;
  localparam int DIR_ENTRIES = 1024;
  localparam int FRAME_BITS  = 20;

  // random part: four phases with a register write in front of each
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_BEATS  = 145;
  localparam int CALM_STRETCH = 40;
  localparam int SETTLE_CYCLES = 16;

  // slowest correct run is every fault building a table with the worst
  // gaps and stalls; the limit allows several times that run's length
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef logic [pfm_pkg::FRAME_W-1:0] frame_t;
  typedef logic [pfm_pkg::IDX_W-1:0]   index_t;

  // one beat of the mapping channel
  typedef struct packed {
    frame_t frame;
    logic   tbl_new;
    logic   page_new;
  } map_beat_t;

  // one row of the directed part; want only counts where typed is set
  typedef struct packed {
    logic [pfm_pkg::ADDR_W-1:0] addr;
    frame_t                     kframe;
    frame_t                     pframe;
    logic                       typed;
    map_beat_t                  want;
  } fault_row_t;

  localparam int DIRECTED_ROWS = 15;

  fault_row_t fault_rows [DIRECTED_ROWS] = '{
    // identity map of table 0: lowest, highest and a middle page
    '{32'h0000_0000, 20'h00000, 20'h00000, 1'b1, '{20'h00000, 1'b0, 1'b0}},
    '{32'h003f_ffff, 20'hfffff, 20'hfffff, 1'b1, '{20'h003ff, 1'b0, 1'b0}},
    '{32'h0012_3abc, 20'h12345, 20'h54321, 1'b1, '{20'h00123, 1'b0, 1'b0}},
    // top directory entry: new table, then page already mapped, then a fresh page
    '{32'hffff_ffff, 20'hfffff, 20'hfffff, 1'b1, '{20'hfffff, 1'b1, 1'b1}},
    '{32'hffff_f000, 20'h00000, 20'h00000, 1'b1, '{20'hfffff, 1'b0, 1'b0}},
    '{32'hffc0_0000, 20'h12345, 20'h00000, 1'b1, '{20'h00000, 1'b0, 1'b1}},
    // second directory entry, built from a zero kernel frame
    '{32'h0040_0000, 20'h00000, 20'habcde, 1'b1, '{20'habcde, 1'b1, 1'b1}},
    '{32'h0040_0fff, 20'hfffff, 20'h00001, 1'b1, '{20'habcde, 1'b0, 1'b0}},
    '{32'h007f_f000, 20'h00001, 20'h55555, 1'b1, '{20'h55555, 1'b0, 1'b1}},
    // alternating bit patterns on every field, then the first page once more
    '{32'haaaa_aaaa, 20'haaaaa, 20'h55555, 1'b1, '{20'h55555, 1'b1, 1'b1}},
    '{32'h5555_5555, 20'h55555, 20'haaaaa, 1'b1, '{20'haaaaa, 1'b1, 1'b1}},
    '{32'haaaa_a000, 20'h00000, 20'h00000, 1'b1, '{20'h55555, 1'b0, 1'b0}},
    // left to the predictor
    '{32'h8000_0000, 20'h0f0f0, 20'h3c3c3, 1'b0, '0},
    '{32'h8000_1234, 20'h0f0f0, 20'hc3c3c, 1'b0, '0},
    '{32'h0040_1000, 20'h11111, 20'h22222, 1'b0, '0}
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  frame_t cfg_wdata = '0;

  pfm_fault_if fault_bus ();
  pfm_map_if   map_bus ();

  two_level_page_fault_mapper #(
    .TABLE_ENTRIES    (TBL_ENTRIES),
    .DIRECTORY_ENTRIES(DIR_ENTRIES),
    .FRAME_BITS       (FRAME_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .fault    (fault_bus),
    .mapping  (map_bus)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // own copy of the directory and page tables; a page entry is valid
  // exactly when its slot exists in page_map
  bit     dir_live [DIR_ENTRIES];
  frame_t dir_frame [DIR_ENTRIES];
  frame_t page_map [int unsigned];
  frame_t first_tbl_frame;

  // results owed by the block, oldest first
  map_beat_t map_expect_q [$];

  int fail_count = 0;
  int cycle_count = 0;

  // when set, neither side idles nor stalls
  bit calm = 1'b0;

  // directory entry 0 valid and identity-mapped, everything else invalid
  function automatic void reset_tables();
    first_tbl_frame = frame_t'(1);
    page_map.delete();
    foreach (dir_live[d]) begin
      dir_live[d]  = 1'b0;
      dir_frame[d] = '0;
    end
    dir_live[0]  = 1'b1;
    dir_frame[0] = first_tbl_frame;
    for (int i = 0; i < TBL_ENTRIES; i++) page_map[i] = frame_t'(i);
  endfunction

  // walks one fault through the tables and returns the mapping it causes
  function automatic map_beat_t map_fault(logic [pfm_pkg::ADDR_W-1:0] addr,
                                          frame_t kf, frame_t pf);
    int unsigned dir;
    int unsigned pg;
    int unsigned slot;
    map_beat_t   res;
    dir  = addr[pfm_pkg::DIR_LSB +: pfm_pkg::IDX_W] % DIR_ENTRIES;
    pg   = addr[pfm_pkg::PAGE_LSB +: pfm_pkg::IDX_W] % TBL_ENTRIES;
    slot = dir * TBL_ENTRIES + pg;
    res  = '0;
    // missing page table: take the kernel frame and clear the whole table
    if (!dir_live[dir]) begin
      dir_live[dir]  = 1'b1;
      dir_frame[dir] = kf;
      for (int i = 0; i < TBL_ENTRIES; i++) page_map.delete(dir * TBL_ENTRIES + i);
      res.tbl_new = 1'b1;
    end
    // missing page: take the process frame
    if (!page_map.exists(slot)) begin
      page_map[slot] = pf;
      res.page_new   = 1'b1;
    end
    res.frame = page_map[slot];
    return res;
  endfunction

  // full range, with the extremes drawn more often
  function automatic frame_t pick_frame();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return frame_t'($urandom);
    endcase
  endfunction

  task automatic write_first_tbl(frame_t value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    first_tbl_frame = value;
    dir_frame[0]    = value;
  endtask

  // one fault beat; valid stays high afterwards so back-to-back beats
  // need no second assignment in the same step
  task automatic send_fault(logic [pfm_pkg::ADDR_W-1:0] addr, frame_t kf, frame_t pf,
                            logic typed, map_beat_t want);
    int unsigned gap;
    map_beat_t   got;
    gap = calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      fault_bus.valid = 1'b0;
    end
    @(negedge clk);
    fault_bus.valid           = 1'b1;
    fault_bus.logical_address = addr;
    fault_bus.kernel_frame    = kf;
    fault_bus.process_frame   = pf;
    do @(posedge clk); while (fault_bus.ready !== 1'b1);
    // the predictor always runs so its tables track the block
    got = map_fault(addr, kf, pf);
    map_expect_q.push_back(typed ? want : got);
  endtask

  // lowers valid and waits until every owed result has come back
  task automatic drain_block();
    @(negedge clk);
    fault_bus.valid = 1'b0;
    while (map_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_beat(map_beat_t got);
    map_beat_t want;
    if (map_expect_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected mapping beat: frame %h table %b page %b",
                 got.frame, got.tbl_new, got.page_new);
    end else begin
      want = map_expect_q.pop_front();
      if (got.frame !== want.frame || got.tbl_new !== want.tbl_new ||
          got.page_new !== want.page_new) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mapping mismatch: expected frame %h table %b page %b, got frame %h table %b page %b",
                   want.frame, want.tbl_new, want.page_new,
                   got.frame, got.tbl_new, got.page_new);
      end
    end
  endtask

  // receiving side: random stall before each beat, check at the edge
  initial begin : result_sink
    int unsigned stall;
    map_beat_t   got;
    map_bus.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        map_bus.ready = 1'b0;
      end
      @(negedge clk);
      map_bus.ready = 1'b1;
      do @(posedge clk); while (map_bus.valid !== 1'b1);
      got.frame    = map_bus.mapped_frame;
      got.tbl_new  = map_bus.table_created;
      got.page_new = map_bus.page_created;
      check_beat(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_level_page_fault_mapper regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    index_t                     dir_pool [8];
    index_t                     page_pool [8];
    index_t                     dir;
    index_t                     pg;
    logic [11:0]                offset;
    logic [pfm_pkg::ADDR_W-1:0] addr;
    frame_t                     cfg_value;
    int unsigned                roll;
    fault_bus.valid           = 1'b0;
    fault_bus.logical_address = '0;
    fault_bus.kernel_frame    = '0;
    fault_bus.process_frame   = '0;
    reset_tables();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register write while the directory sweep is still running
    write_first_tbl('1);

    foreach (fault_rows[i])
      send_fault(fault_rows[i].addr, fault_rows[i].kframe, fault_rows[i].pframe,
                 fault_rows[i].typed, fault_rows[i].want);

    // a few directories and pages that keep coming back, so most faults
    // land in existing tables and often on pages already mapped
    dir_pool[0]  = '0;
    dir_pool[1]  = index_t'(1);
    dir_pool[2]  = '1;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 3; i < 8; i++) dir_pool[i] = index_t'($urandom);
    for (int i = 2; i < 8; i++) page_pool[i] = index_t'($urandom);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_block();
      case (phase)
        0:       cfg_value = '0;
        1:       cfg_value = frame_t'($urandom);
        2:       cfg_value = frame_t'(1);
        default: cfg_value = '1;
      endcase
      write_first_tbl(cfg_value);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n % CALM_STRETCH == 0) calm = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // anywhere at all: usually builds a fresh table
          addr = $urandom;
        end else begin
          dir    = dir_pool[$urandom_range(0, 7)];
          pg     = (roll < 55) ? page_pool[$urandom_range(0, 7)] : index_t'($urandom);
          offset = 12'($urandom);
          addr   = {dir, pg, offset};
        end
        send_fault(addr, pick_frame(), pick_frame(), 1'b0, '0);
      end
    end

    drain_block();

    if (fail_count == 0 && map_expect_q.size() == 0) begin
      $display("two_level_page_fault_mapper regression: pass");
    end else begin
      $display("two_level_page_fault_mapper regression: fail");
    end
    $finish;
  end

endmodule
